>>> rtl/core/crc16_configurable_bytewise_defines.svh
// Assertion macros shared by the CRC-16 byte engine modules.
// Each use expects clk_i, and CRC16CB_ASSERT also rst_ni, to be visible in the calling module.
`ifndef CRC16_CONFIGURABLE_BYTEWISE_DEFINES_SVH
`define CRC16_CONFIGURABLE_BYTEWISE_DEFINES_SVH

// Clocked check, disabled while reset is asserted.
`define CRC16CB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define CRC16CB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/core/crc16cb_pkg.sv
// Package for the configurable CRC-16 byte engine: types, constants and
// the bit reversal and eight-step CRC update functions. No dependencies.
package crc16cb_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CrcW      = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned FifoDepth = 2;

  localparam logic [CrcW-1:0] InitReset   = 16'h0000;
  localparam logic [CrcW-1:0] PolyReset   = 16'h1021;
  localparam logic [CrcW-1:0] LsbMask     = 16'h0001;
  localparam logic [CrcW-1:0] MsbMask     = 16'h8000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INIT    = 2'd0,
    CFG_POLY    = 2'd1,
    CFG_REFLECT = 2'd2
  } cfg_idx_e;

  // One queued byte: data already bit-reversed in reflect mode.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } entry_t;

  function automatic logic [ByteW-1:0] rev8(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] r;
    for (int i = 0; i < ByteW; i++) begin
      r[i] = v[ByteW-1-i];
    end
    return r;
  endfunction

  function automatic logic [CrcW-1:0] rev16(input logic [CrcW-1:0] v);
    logic [CrcW-1:0] r;
    for (int i = 0; i < CrcW; i++) begin
      r[i] = v[CrcW-1-i];
    end
    return r;
  endfunction

  // Eight XOR-shift steps; byte b enters the high byte (normal) or low byte (reflect).
  function automatic logic [CrcW-1:0] crc_step8(input logic [CrcW-1:0]  c_in,
                                               input logic [ByteW-1:0] b,
                                               input logic [CrcW-1:0]  poly,
                                               input logic             reflect);
    logic [CrcW-1:0] c;
    if (reflect) begin
      c = c_in ^ {{(CrcW-ByteW){1'b0}}, b};
      for (int k = 0; k < 8; k++) begin
        if ((c & LsbMask) != '0) begin
          c = (c >> 1) ^ poly;
        end else begin
          c = c >> 1;
        end
      end
    end else begin
      c = c_in ^ {b, {(CrcW-ByteW){1'b0}}};
      for (int k = 0; k < 8; k++) begin
        if ((c & MsbMask) != '0) begin
          c = (c << 1) ^ poly;
        end else begin
          c = c << 1;
        end
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/crc16_configurable_bytewise.sv
// Configurable CRC-16, one byte per cycle while the queue has room; one result
// per byte marked last. Throughput: one byte per cycle, held while a last byte
// waits for a full output register; the eight XOR-shift steps of the back end
// form one combinational stage between queue and CRC register.
// Reset (async, active low): queue and output empty, CRC restarts at the
// initial value, registers return to init 0x0000, poly 0x1021, normal mode.
module crc16_configurable_bytewise #(
  parameter int unsigned FifoDepth = crc16cb_pkg::FifoDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,   // [7:0] data_byte
  input  logic                                 s_tlast,   // last_byte
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [15:0]                          m_tdata,   // [15:0] crc_value
  input  logic                                 cfg_we_i,
  input  logic [crc16cb_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [15:0]                          cfg_data_i
);

  logic [crc16cb_pkg::CrcW-1:0] init_q, poly_q;
  logic                         reflect_q;

  logic                q_push, q_ready, q_pop, q_valid;
  crc16cb_pkg::entry_t q_wr_entry, q_rd_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= crc16cb_pkg::InitReset;
      poly_q    <= crc16cb_pkg::PolyReset;
      reflect_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (crc16cb_pkg::cfg_idx_e'(cfg_idx_i))
        crc16cb_pkg::CFG_INIT:    init_q    <= cfg_data_i;
        crc16cb_pkg::CFG_POLY:    poly_q    <= cfg_data_i;
        crc16cb_pkg::CFG_REFLECT: reflect_q <= cfg_data_i[0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  crc16cb_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .reflect_i (reflect_q),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_entry_o (q_wr_entry)
  );

  crc16cb_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_wr_entry),
    .push_ready_o (q_ready),
    .pop_i        (q_pop),
    .pop_entry_o  (q_rd_entry),
    .pop_valid_o  (q_valid)
  );

  crc16cb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .init_i    (init_q),
    .poly_i    (poly_q),
    .reflect_i (reflect_q),
    .q_valid_i (q_valid),
    .q_entry_i (q_rd_entry),
    .q_pop_o   (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

>>> rtl/core/crc16cb_fifo.sv
// Short queue between the byte front end and the CRC back end.
// Depends on crc16cb_pkg (entry_t) and the assertion macro header.
`include "crc16_configurable_bytewise_defines.svh"

module crc16cb_fifo #(
  parameter int unsigned Depth = crc16cb_pkg::FifoDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  crc16cb_pkg::entry_t  push_entry_i,
  output logic                 push_ready_o,
  input  logic                 pop_i,
  output crc16cb_pkg::entry_t  pop_entry_o,
  output logic                 pop_valid_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] Full    = CW'(Depth);

  crc16cb_pkg::entry_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  `CRC16CB_ASSERT(a_fill_up, do_push && !do_pop |=> count_q == $past(count_q) + CW'(1), "no push")
  `CRC16CB_ASSERT(a_drain, do_pop && !do_push |=> count_q == $past(count_q) - CW'(1), "no pop")
  `CRC16CB_ASSERT(a_bound, count_q <= Full, "queue count exceeds depth")

endmodule

>>> rtl/core/crc16cb_front.sv
// Front end: accepts message bytes and shapes them into queue entries.
// Depends on crc16cb_pkg (entry_t, rev8).
module crc16cb_front (
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [crc16cb_pkg::ByteW-1:0]        s_tdata,
  input  logic                                 s_tlast,
  input  logic                                 reflect_i,
  input  logic                                 q_ready_i,
  output logic                                 q_push_o,
  output crc16cb_pkg::entry_t                  q_entry_o
);

  assign s_tready = q_ready_i;
  assign q_push_o = s_tvalid && q_ready_i;

  // Reflect mode feeds the byte bit-reversed into the low end of the CRC.
  always_comb begin
    q_entry_o.data = reflect_i ? crc16cb_pkg::rev8(s_tdata) : s_tdata;
    q_entry_o.last = s_tlast;
  end

endmodule

>>> rtl/core/crc16cb_back.sv
// Back end: runs the eight-step CRC update per queued byte and holds the
// finished CRC in an output register. Depends on crc16cb_pkg and the macro header.
`include "crc16_configurable_bytewise_defines.svh"

module crc16cb_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [crc16cb_pkg::CrcW-1:0]      init_i,
  input  logic [crc16cb_pkg::CrcW-1:0]      poly_i,
  input  logic                              reflect_i,
  input  logic                              q_valid_i,
  input  crc16cb_pkg::entry_t               q_entry_i,
  output logic                              q_pop_o,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [crc16cb_pkg::CrcW-1:0]      m_tdata
);

  logic [crc16cb_pkg::CrcW-1:0] crc_q, crc_d;
  logic                         start_q, start_d;
  logic                         out_valid_q, out_valid_d;
  logic [crc16cb_pkg::CrcW-1:0] out_data_q, out_data_d;
  logic [crc16cb_pkg::CrcW-1:0] crc_seed, crc_next;
  logic                         out_free;

  assign out_free = !out_valid_q || m_tready;
  // A plain byte always drains; a last byte waits for room in the output register.
  assign q_pop_o  = q_valid_i && (!q_entry_i.last || out_free);

  assign crc_seed = start_q ? init_i : crc_q;
  assign crc_next = crc16cb_pkg::crc_step8(crc_seed, q_entry_i.data, poly_i, reflect_i);

  always_comb begin
    crc_d       = crc_q;
    start_d     = start_q;
    out_valid_d = out_valid_q && !m_tready;
    out_data_d  = out_data_q;
    if (q_pop_o) begin
      crc_d   = crc_next;
      start_d = q_entry_i.last;
      if (q_entry_i.last) begin
        out_valid_d = 1'b1;
        out_data_d  = reflect_i ? crc16cb_pkg::rev16(crc_next) : crc_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= crc16cb_pkg::InitReset;
      start_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = out_data_q;

  `CRC16CB_ASSERT(a_last_emits, q_pop_o && q_entry_i.last |=> out_valid_q && start_q, "last byte did not produce a result")
  `CRC16CB_ASSERT(a_mid_message, q_pop_o && !q_entry_i.last |=> !start_q, "message start not cleared after a plain byte")

endmodule
